>>> hw/rtl/lsoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsoa_pkg;

    // Store geometry and widths.
    localparam int MAX_SAMPLES      = 512;
    localparam int IDX_W            = $clog2(MAX_SAMPLES);
    localparam int LEN_W            = IDX_W + 1;
    localparam int RANGE_W          = 16;
    localparam int MIN_W            = RANGE_W + 1;
    localparam int SUM_W            = RANGE_W + IDX_W;
    localparam int FRONT_HALF_WIDTH = 30;
    localparam int DIV_STEPS_W      = $clog2(SUM_W + 1);

    localparam logic [MIN_W-1:0] RANGE_INF = {1'b1, {RANGE_W{1'b0}}};

    // Speed commands.
    localparam logic [7:0] SPEED_FORWARD    = 8'd160;
    localparam logic [7:0] SPEED_GENTLE_FWD = 8'd60;
    localparam logic [7:0] SPEED_STRONG_FWD = 8'd0;
    localparam logic signed [9:0] TURN_GENTLE = 10'sd280;
    localparam logic signed [9:0] TURN_STRONG = 10'sd400;
    localparam logic [3:0] CLEAR_SAT = 4'd15;

    // Turn directions.
    localparam logic signed [1:0] DIR_NONE  = 2'sb00;
    localparam logic signed [1:0] DIR_LEFT  = 2'sb01;
    localparam logic signed [1:0] DIR_RIGHT = 2'sb11;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ENTER      = 3'd0,
        REG_EXIT       = 3'd1,
        REG_CORNER     = 3'd2,
        REG_SIDE_WALL  = 3'd3,
        REG_VERY_CLOSE = 3'd4,
        REG_OPEN_BIAS  = 3'd5,
        REG_CLEAR_TICKS = 3'd6
    } reg_idx_t;

    // Tick sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_L,
        ST_WAIT_L,
        ST_DIV_R,
        ST_WAIT_R,
        ST_DECIDE
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [LEN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [RANGE_W-1:0] quotient;
    } div_rsp_t;

    // Floor of x / 3 for x below 1366, by reciprocal multiplication.
    function automatic logic [LEN_W-1:0] div3(input logic [LEN_W:0] x);
        logic [LEN_W+11:0] prod;
        begin
            prod = {11'd0, x} * (LEN_W + 12)'(683);
            div3 = prod[LEN_W+10:11];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lsoa_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample and tick request channel.
interface lsoa_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic [8:0]          sample_index;
    logic [15:0]         range_mm;
    logic                range_valid;
    logic                last_of_scan;

    modport source (output valid, action, sample_index, range_mm, range_valid,
                    last_of_scan, input ready);
    modport sink (input valid, action, sample_index, range_mm, range_valid,
                  last_of_scan, output ready);
endinterface

// Speed command channel.
interface lsoa_out_if;
    logic                valid;
    logic                ready;
    logic [7:0]          linear_speed_mm_s;
    logic signed [9:0]   angular_speed_mrad_s;
    logic signed [1:0]   turn_dir;
    logic                avoiding;

    modport source (output valid, linear_speed_mm_s, angular_speed_mrad_s, turn_dir,
                    avoiding, input ready);
    modport sink (input valid, linear_speed_mm_s, angular_speed_mrad_s, turn_dir,
                  avoiding, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lsoa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lsoa_div
    import lsoa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [SUM_W-1:0]       quo_reg;
    logic [LEN_W-1:0]       rem_reg;
    logic [LEN_W-1:0]       divisor_reg;
    logic [DIV_STEPS_W-1:0] steps_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [LEN_W:0]         trial;
    logic                   fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                steps_reg <= DIV_STEPS_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                steps_reg <= steps_reg - 1'b1;
                if (steps_reg == DIV_STEPS_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? LEN_W'(trial - {1'b0, divisor_reg}) : trial[LEN_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[RANGE_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/lidar_sector_obstacle_avoider.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample requests can follow back to back while no tick is in progress.
// A tick request on a scan of n samples passes through the setup, a walk over the n entries
// through the store's single read port, a drain, and two divisions of a start and a wait
// each, then the decision, which holds until the output register is free.
// A tick with no scan goes straight to the decision. Input is held off
// from a tick's acceptance until its result has entered the output register.
// Reset clears the scan length, turn direction, clear count, state and output valid,
// and loads the configuration defaults; the store is not cleared.
module lidar_sector_obstacle_avoider
    import lsoa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    lsoa_in_if.sink         in_ch,
    lsoa_out_if.source      out_ch,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [RANGE_W-1:0] enter_reg, exit_reg, corner_reg, side_reg, vclose_reg, bias_reg;
    logic [3:0]         need_reg;

    logic [MIN_W-1:0]   mem [MAX_SAMPLES];
    logic [MIN_W-1:0]   rd_data_reg;
    logic [LEN_W-1:0]   len_reg;
    logic signed [1:0]  dir_reg;
    logic [3:0]         clear_reg;

    logic [LEN_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic               pend_reg;

    logic [LEN_W-1:0]   front_lo_reg, b8_reg, b4_reg, b38_reg, b58_reg, b34_reg, b78_reg;
    logic [LEN_W-1:0]   b6_reg, b3_reg, b23_reg, b56_reg;

    logic [MIN_W-1:0]   fmin_reg, flmin_reg, frmin_reg, lmin_reg, rmin_reg;
    logic [SUM_W-1:0]   suml_reg, sumr_reg;
    logic [LEN_W-1:0]   cntl_reg, cntr_reg;
    logic [RANGE_W-1:0] lopen_reg, ropen_reg;

    logic               out_valid_reg;
    logic [7:0]         lin_reg;
    logic signed [9:0]  ang_reg;
    logic signed [1:0]  tdir_reg;
    logic               avoid_out_reg;

    logic               in_acc, is_sample, is_tick, out_free, decide_fire;
    logic               e_valid;
    logic [RANGE_W-1:0] e_range;
    div_req_t           dreq;
    div_rsp_t           drsp;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign is_sample   = in_acc && !in_ch.action;
    assign is_tick     = in_acc && in_ch.action;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign decide_fire = (state_reg == ST_DECIDE) && out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_reg  <= 16'd420;
            exit_reg   <= 16'd550;
            corner_reg <= 16'd300;
            side_reg   <= 16'd220;
            vclose_reg <= 16'd260;
            bias_reg   <= 16'd50;
            need_reg   <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ENTER:       enter_reg  <= cfg_data;
                REG_EXIT:        exit_reg   <= cfg_data;
                REG_CORNER:      corner_reg <= cfg_data;
                REG_SIDE_WALL:   side_reg   <= cfg_data;
                REG_VERY_CLOSE:  vclose_reg <= cfg_data;
                REG_OPEN_BIAS:   bias_reg   <= cfg_data;
                REG_CLEAR_TICKS: need_reg   <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Scan store: written by samples, read once a cycle during the walk.
    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            mem[in_ch.sample_index] <= {in_ch.range_valid, in_ch.range_mm};
        end
        rd_data_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dreq.start    = 1'b0;
        dreq.dividend = suml_reg;
        dreq.divisor  = cntl_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_tick)
                begin
                    state_next = (len_reg == '0) ? ST_DECIDE : ST_SETUP;
                end
            end
            ST_SETUP:  state_next = ST_WALK;
            ST_WALK:
            begin
                if (cnt_reg == len_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DIV_L;
            ST_DIV_L:
            begin
                dreq.start = 1'b1;
                state_next = ST_WAIT_L;
            end
            ST_WAIT_L:
            begin
                if (drsp.done)
                begin
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = sumr_reg;
                dreq.divisor  = cntr_reg;
                state_next    = ST_WAIT_R;
            end
            ST_WAIT_R:
            begin
                if (drsp.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    lsoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Walk address counter and read tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= (state_reg == ST_WALK);
            if (state_reg == ST_SETUP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_WALK)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Sector bounds, fixed for the whole walk.
    always_ff @(posedge clk)
    begin
        idx_reg <= cnt_reg;
        if (state_reg == ST_SETUP)
        begin
            front_lo_reg <= (len_reg > LEN_W'(FRONT_HALF_WIDTH))
                          ? LEN_W'(len_reg - LEN_W'(FRONT_HALF_WIDTH)) : '0;
            b8_reg  <= LEN_W'(len_reg >> 3);
            b4_reg  <= LEN_W'(len_reg >> 2);
            b38_reg <= LEN_W'(({2'b0, len_reg} * 12'd3) >> 3);
            b58_reg <= LEN_W'(({2'b0, len_reg} * 12'd5) >> 3);
            b34_reg <= LEN_W'(({2'b0, len_reg} * 12'd3) >> 2);
            b78_reg <= LEN_W'(({2'b0, len_reg} * 12'd7) >> 3);
            b6_reg  <= div3({2'b0, len_reg[LEN_W-1:1]});
            b3_reg  <= div3({1'b0, len_reg});
            b23_reg <= div3({len_reg, 1'b0});
            b56_reg <= div3((LEN_W+1)'(({2'b0, len_reg} * 12'd5) >> 1));
        end
    end

    // Sector accumulation on each returned store entry.
    assign e_valid = rd_data_reg[RANGE_W];
    assign e_range = rd_data_reg[RANGE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            fmin_reg  <= RANGE_INF;
            flmin_reg <= RANGE_INF;
            frmin_reg <= RANGE_INF;
            lmin_reg  <= RANGE_INF;
            rmin_reg  <= RANGE_INF;
            suml_reg  <= '0;
            sumr_reg  <= '0;
            cntl_reg  <= '0;
            cntr_reg  <= '0;
        end
        else if (pend_reg && e_valid)
        begin
            if ((idx_reg <= LEN_W'(FRONT_HALF_WIDTH - 1) || idx_reg >= front_lo_reg)
                && {1'b0, e_range} < fmin_reg)
                fmin_reg <= {1'b0, e_range};
            if (idx_reg >= b8_reg && idx_reg <= b4_reg && {1'b0, e_range} < flmin_reg)
                flmin_reg <= {1'b0, e_range};
            if (idx_reg >= b34_reg && idx_reg <= b78_reg && {1'b0, e_range} < frmin_reg)
                frmin_reg <= {1'b0, e_range};
            if (idx_reg >= b4_reg && idx_reg <= b38_reg && {1'b0, e_range} < lmin_reg)
                lmin_reg <= {1'b0, e_range};
            if (idx_reg >= b58_reg && idx_reg <= b34_reg && {1'b0, e_range} < rmin_reg)
                rmin_reg <= {1'b0, e_range};
            if (idx_reg >= b6_reg && idx_reg <= b3_reg)
            begin
                suml_reg <= suml_reg + SUM_W'(e_range);
                cntl_reg <= cntl_reg + 1'b1;
            end
            if (idx_reg >= b23_reg && idx_reg <= b56_reg)
            begin
                sumr_reg <= sumr_reg + SUM_W'(e_range);
                cntr_reg <= cntr_reg + 1'b1;
            end
        end
    end

    // Open-sector averages; an empty sector averages to zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT_L && drsp.done)
            lopen_reg <= (cntl_reg == '0) ? '0 : drsp.quotient;
        if (state_reg == ST_WAIT_R && drsp.done)
            ropen_reg <= (cntr_reg == '0) ? '0 : drsp.quotient;
    end

    // Decision: hysteresis, committed direction and speed commands.
    logic               lfb, rfb, lwc, rwc, risk, avoid, vclose;
    logic signed [1:0]  dir_new;
    logic [3:0]         clear_new;
    logic [7:0]         lin_new;
    logic signed [9:0]  ang_new;

    always_comb
    begin
        lfb  = flmin_reg < {1'b0, corner_reg};
        rfb  = frmin_reg < {1'b0, corner_reg};
        lwc  = lmin_reg < {1'b0, side_reg};
        rwc  = rmin_reg < {1'b0, side_reg};
        risk = lfb || rfb || lwc || rwc;
        vclose = fmin_reg < {1'b0, vclose_reg};
        if (dir_reg == DIR_NONE)
            avoid = (fmin_reg < {1'b0, enter_reg}) || risk;
        else
            avoid = !(fmin_reg > {1'b0, exit_reg}) || risk;
        dir_new   = dir_reg;
        clear_new = clear_reg;
        lin_new   = SPEED_FORWARD;
        ang_new   = '0;
        if (avoid)
        begin
            clear_new = '0;
            if (dir_reg == DIR_NONE)
            begin
                if (lwc || lfb)
                    dir_new = DIR_RIGHT;
                else if (rwc || rfb)
                    dir_new = DIR_LEFT;
                else if ({1'b0, lopen_reg} > {1'b0, ropen_reg} + {1'b0, bias_reg})
                    dir_new = DIR_LEFT;
                else if ({1'b0, ropen_reg} > {1'b0, lopen_reg} + {1'b0, bias_reg})
                    dir_new = DIR_RIGHT;
                else
                    dir_new = DIR_LEFT;
            end
            if ((dir_new == DIR_LEFT && lwc) || (dir_new == DIR_RIGHT && rwc) || vclose)
                lin_new = SPEED_STRONG_FWD;
            else
                lin_new = SPEED_GENTLE_FWD;
            if (dir_new == DIR_LEFT)
                ang_new = vclose ? TURN_STRONG : TURN_GENTLE;
            else
                ang_new = vclose ? -TURN_STRONG : -TURN_GENTLE;
        end
        else
        begin
            if (clear_reg < CLEAR_SAT)
                clear_new = clear_reg + 1'b1;
            if (clear_new >= need_reg)
                dir_new = DIR_NONE;
        end
    end

    // Scan length and steering state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            dir_reg   <= DIR_NONE;
            clear_reg <= '0;
        end
        else
        begin
            if (is_sample && in_ch.last_of_scan)
                len_reg <= LEN_W'(in_ch.sample_index) + 1'b1;
            if (decide_fire && len_reg != '0)
            begin
                dir_reg   <= dir_new;
                clear_reg <= clear_new;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (decide_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide_fire)
        begin
            if (len_reg == '0)
            begin
                lin_reg       <= SPEED_STRONG_FWD;
                ang_reg       <= '0;
                tdir_reg      <= dir_reg;
                avoid_out_reg <= 1'b0;
            end
            else
            begin
                lin_reg       <= lin_new;
                ang_reg       <= ang_new;
                tdir_reg      <= avoid ? dir_new : dir_new;
                avoid_out_reg <= avoid;
            end
        end
    end

    assign out_ch.valid                = out_valid_reg;
    assign out_ch.linear_speed_mm_s    = lin_reg;
    assign out_ch.angular_speed_mrad_s = ang_reg;
    assign out_ch.turn_dir             = tdir_reg;
    assign out_ch.avoiding             = avoid_out_reg;

    // The committed direction is never the unused code.
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg != 2'sb10)
        else $error("committed direction holds an unused code");

    // A result is only launched from the decision step.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result raised outside the decision step");

    // An avoiding result always carries a turn direction.
    a_avoid_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && avoid_out_reg |-> tdir_reg != DIR_NONE)
        else $error("avoiding result without a turn direction");

    // Sector counts do not exceed the scan length when the divisions start.
    a_cnt_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_L |-> cntl_reg <= len_reg && cntr_reg <= len_reg)
        else $error("open sector count exceeds scan length");

endmodule

`default_nettype wire
